// ===== sv/ppurp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppurp_pkg
// Shared types, codes and address mapping for the video processor register
// port.
// ----------------------------------------------------------------------------
`default_nettype none

package ppurp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int VID_AW      = 14;
    localparam int SPR_AW      = 8;

    localparam logic [1:0] MODE_READ   = 2'd0;
    localparam logic [1:0] MODE_WRITE  = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STAT     = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_STATUS,
        RD_SPRITE,
        RD_BUFFER,
        RD_PALETTE
    } rd_kind_t;

    typedef struct packed {
        logic              vid_we;
        logic [VID_AW-1:0] vid_addr_a;
        logic [VID_AW-1:0] vid_addr_b;
        logic              spr_we;
        logic [SPR_AW-1:0] spr_addr;
        logic [7:0]        wdata;
        rd_kind_t          rd_kind;
        logic [2:0]        status;
        logic [14:0]       vram_addr;
        logic [14:0]       temp_addr;
        logic [2:0]        fine_x;
        logic              toggle;
        logic [7:0]        ctrl;
        logic [7:0]        mask;
    } cmd_t;

    // Folds a video address onto the physical 16K store: nametable mirroring
    // and the palette aliases of the backdrop entries.
    function automatic logic [VID_AW-1:0] map_video(input logic [VID_AW-1:0] a,
                                                     input logic mirror);
        logic [VID_AW-1:0] r;
        r = a;
        if (a >= 14'h2000 && a <= 14'h3EFF) begin
            r = a & 14'h2FFF;
            if (mirror) begin
                r[11] = 1'b0;
            end
            else begin
                r[10] = 1'b0;
            end
        end
        else if (a >= 14'h3F00) begin
            r = a & 14'h3F1F;
            if ((r & 14'h0013) == 14'h0010) begin
                r[4] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ppurp_front.sv =====
// ----------------------------------------------------------------------------
// ppurp_front
// Accepts register accesses, updates the scroll, address and control
// registers and issues memory commands to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  cfg_write,
    input  wire                  cfg_data,
    input  wire                  accept,
    input  wire  [1:0]           mode,
    input  wire  [2:0]           reg_index,
    input  wire  [7:0]           write_data,
    output ppurp_pkg::cmd_t      cmd
);
    import ppurp_pkg::*;

    logic        mirror_reg;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [14:0] t_reg, t_next;
    logic [14:0] v_reg, v_next;
    logic [2:0]  fine_reg, fine_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  oam_reg, oam_next;
    logic [14:0] step;
    logic [VID_AW-1:0] map_a;

    assign step  = ctrl_reg[2] ? 15'd32 : 15'd1;
    assign map_a = map_video(v_reg[13:0], mirror_reg);

    always_comb
    begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        t_next      = t_reg;
        v_next      = v_reg;
        fine_next   = fine_reg;
        toggle_next = toggle_reg;
        oam_next    = oam_reg;
        cmd         = '0;
        cmd.rd_kind = RD_NONE;
        cmd.wdata   = write_data;
        cmd.status  = status_reg;
        if (accept)
        begin
            case (mode)
                MODE_READ:
                begin
                    case (reg_index)
                        REG_STAT:
                        begin
                            cmd.rd_kind = RD_STATUS;
                            status_next = {1'b0, status_reg[1:0]};
                            toggle_next = 1'b0;
                        end
                        REG_OAM_DATA:
                        begin
                            cmd.rd_kind  = RD_SPRITE;
                            cmd.spr_addr = oam_reg;
                        end
                        REG_DATA:
                        begin
                            cmd.vid_addr_a = map_a;
                            cmd.vid_addr_b = map_video(v_reg[13:0] & 14'h2FFF, mirror_reg);
                            cmd.rd_kind    = (map_a >= 14'h3F00) ? RD_PALETTE : RD_BUFFER;
                            v_next         = v_reg + step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_WRITE:
                begin
                    case (reg_index)
                        REG_CTRL:
                        begin
                            ctrl_next = write_data;
                            t_next    = (t_reg & 15'h73FF) | {3'b000, write_data[1:0], 10'd0};
                        end
                        REG_MASK:
                        begin
                            mask_next = write_data;
                        end
                        REG_OAM_ADDR:
                        begin
                            oam_next = write_data;
                        end
                        REG_OAM_DATA:
                        begin
                            cmd.spr_we   = 1'b1;
                            cmd.spr_addr = oam_reg;
                            oam_next     = oam_reg + 8'd1;
                        end
                        REG_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                t_next      = {t_reg[14:5], write_data[7:3]};
                                fine_next   = write_data[2:0];
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                t_next      = {write_data[2:0], t_reg[11:10],
                                               write_data[7:3], t_reg[4:0]};
                                toggle_next = 1'b0;
                            end
                        end
                        REG_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                t_next      = {1'b0, write_data[5:0], t_reg[7:0]};
                                toggle_next = 1'b1;
                            end
                            else
                            begin
                                t_next      = {t_reg[14:8], write_data};
                                v_next      = {t_reg[14:8], write_data};
                                toggle_next = 1'b0;
                            end
                        end
                        REG_DATA:
                        begin
                            cmd.vid_we     = 1'b1;
                            cmd.vid_addr_a = map_a;
                            v_next         = v_reg + step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                MODE_STATUS:
                begin
                    status_next = write_data[7:5];
                end
                default:
                begin
                end
            endcase
        end
        cmd.vram_addr = v_next;
        cmd.temp_addr = t_next;
        cmd.fine_x    = fine_next;
        cmd.toggle    = toggle_next;
        cmd.ctrl      = ctrl_next;
        cmd.mask      = mask_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
            ctrl_reg   <= '0;
            mask_reg   <= '0;
            status_reg <= '0;
            t_reg      <= '0;
            v_reg      <= '0;
            fine_reg   <= '0;
            toggle_reg <= 1'b0;
            oam_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                mirror_reg <= cfg_data;
            end
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            status_reg <= status_next;
            t_reg      <= t_next;
            v_reg      <= v_next;
            fine_reg   <= fine_next;
            toggle_reg <= toggle_next;
            oam_reg    <= oam_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ppurp_queue.sv =====
// ----------------------------------------------------------------------------
// ppurp_queue
// Small command queue between the front end and the memory back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_queue #(
    parameter int DEPTH = ppurp_pkg::QUEUE_DEPTH
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  ppurp_pkg::cmd_t      push_data,
    input  wire                  pop,
    output ppurp_pkg::cmd_t      pop_data,
    output logic                 full,
    output logic                 empty
);
    import ppurp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ppurp_back.sv =====
// ----------------------------------------------------------------------------
// ppurp_back
// Memory back end: video and sprite stores, the delayed read buffer and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ppurp_pkg::cmd_t      cmd,
    input  wire                  cmd_empty,
    output logic                 cmd_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  wire                  out_stall,
    output logic [7:0]           read_data,
    output logic [14:0]          vram_addr,
    output logic [14:0]          temp_addr,
    output logic [2:0]           fine_x,
    output logic                 write_toggle,
    output logic [7:0]           control_reg,
    output logic [7:0]           mask_reg
);
    import ppurp_pkg::*;

    logic [7:0] vid_mem [2**VID_AW];
    logic [7:0] spr_mem [2**SPR_AW];

    logic [VID_AW:0] clr_cnt_reg;
    logic            m_valid_reg;
    cmd_t            m_cmd_reg;
    logic [7:0]      vid_a_q, vid_b_q, spr_q;
    logic [7:0]      rbuf_reg, rbuf_next;
    logic [7:0]      rd_value;
    logic            out_free, m_move;

    assign clearing = !clr_cnt_reg[VID_AW];
    assign out_free = !out_valid || !out_stall;
    assign m_move   = m_valid_reg && out_free;
    assign cmd_pop  = !clearing && !cmd_empty && (!m_valid_reg || m_move);

    // The whole video store is zeroed after reset, one byte a cycle; the
    // sprite store is zeroed in the first pass through its address range.
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            vid_mem[clr_cnt_reg[VID_AW-1:0]] <= 8'd0;
            spr_mem[clr_cnt_reg[SPR_AW-1:0]] <= 8'd0;
        end
        else if (cmd_pop)
        begin
            if (cmd.vid_we)
            begin
                vid_mem[cmd.vid_addr_a] <= cmd.wdata;
            end
            if (cmd.spr_we)
            begin
                spr_mem[cmd.spr_addr] <= cmd.wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            vid_a_q   <= vid_mem[cmd.vid_addr_a];
            vid_b_q   <= vid_mem[cmd.vid_addr_b];
            spr_q     <= spr_mem[cmd.spr_addr];
            m_cmd_reg <= cmd;
        end
    end

    always_comb
    begin
        rbuf_next = rbuf_reg;
        case (m_cmd_reg.rd_kind)
            RD_STATUS:  rd_value = {m_cmd_reg.status, rbuf_reg[4:0]};
            RD_SPRITE:  rd_value = spr_q;
            RD_BUFFER:
            begin
                rd_value  = rbuf_reg;
                rbuf_next = vid_a_q;
            end
            RD_PALETTE:
            begin
                rd_value  = vid_a_q;
                rbuf_next = vid_b_q;
            end
            default:    rd_value = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            out_valid   <= 1'b0;
            rbuf_reg    <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_move)
            begin
                m_valid_reg <= 1'b0;
            end
            if (m_move)
            begin
                out_valid <= 1'b1;
                rbuf_reg  <= rbuf_next;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_move)
        begin
            read_data    <= rd_value;
            vram_addr    <= m_cmd_reg.vram_addr;
            temp_addr    <= m_cmd_reg.temp_addr;
            fine_x       <= m_cmd_reg.fine_x;
            write_toggle <= m_cmd_reg.toggle;
            control_reg  <= m_cmd_reg.ctrl;
            mask_reg     <= m_cmd_reg.mask;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ppu_cpu_register_port.sv =====
// ----------------------------------------------------------------------------
// ppu_cpu_register_port
// CPU-side register port of a tile video processor with loopy scroll
// registers, a sprite store and a 16K video store.
// ----------------------------------------------------------------------------
// One access is taken every clock cycle while in_stall is low. Register state
// is updated at once in the front end; memory work goes through a short queue
// to the back end, which reads the stores into its read registers and then
// loads the result register from them, raising out_valid with it; a stall at
// the output holds the command between the two.
// After reset the block zeroes the video store, which holds off requests
// until it is done; configuration writes are taken during that time.
`default_nettype none

module ppu_cpu_register_port #(
    parameter int QUEUE_DEPTH = ppurp_pkg::QUEUE_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_write,
    input  wire         cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [1:0]  mode,
    input  wire  [2:0]  reg_index,
    input  wire  [7:0]  write_data,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [7:0]  read_data,
    output logic [14:0] vram_addr,
    output logic [14:0] temp_addr,
    output logic [2:0]  fine_x,
    output logic        write_toggle,
    output logic [7:0]  control_reg,
    output logic [7:0]  mask_reg
);
    import ppurp_pkg::*;

    cmd_t push_cmd, pop_cmd;
    logic accept, q_full, q_empty, q_pop, clearing;

    assign in_stall = q_full || clearing;
    assign accept   = in_valid && !in_stall;

    ppurp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .mode       (mode),
        .reg_index  (reg_index),
        .write_data (write_data),
        .cmd        (push_cmd)
    );

    ppurp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .full      (q_full),
        .empty     (q_empty)
    );

    ppurp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_empty    (q_empty),
        .cmd_pop      (q_pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .vram_addr    (vram_addr),
        .temp_addr    (temp_addr),
        .fine_x       (fine_x),
        .write_toggle (write_toggle),
        .control_reg  (control_reg),
        .mask_reg     (mask_reg)
    );

endmodule

`default_nettype wire
